@@ rtl/pdte_pkg.sv @@
// shared types and constants for the packed date to epoch seconds converter
`timescale 1ns / 1ps

package pdte_pkg;

  localparam logic [15:0]        RECIP_12      = 16'd171;     // floor(m/12) = (m*171) >> 11
  localparam int unsigned        RECIP_12_SH   = 11;
  localparam logic [17:0]        RECIP_100     = 18'd167773;  // ceil(2^24 / 100)
  localparam logic [15:0]        RECIP_400     = 16'd41944;   // ceil(2^24 / 400)
  localparam int unsigned        RECIP_SH      = 24;
  localparam logic [3:0]         MONTH_DEC     = 4'd11;
  localparam logic [3:0]         MONTH_FEB     = 4'd1;
  localparam logic signed [17:0] YEAR_EPOCH    = 18'sd1970;
  localparam logic signed [17:0] YEAR_LEAP4    = 18'sd1968;
  localparam logic signed [17:0] YEAR_LEAP100  = 18'sd1900;
  localparam logic signed [17:0] YEAR_LEAP400  = 18'sd1600;
  localparam logic signed [9:0]  DAYS_PER_YEAR = 10'sd365;
  localparam logic signed [17:0] SEC_PER_DAY   = 18'sd86400;

  typedef struct packed {
    logic signed [17:0] yd;
    logic [8:0]         dbm;
    logic [7:0]         day;
    logic [15:0]        mag4;
    logic [15:0]        mag100;
    logic [15:0]        mag400;
    logic               neg4;
    logic               neg100;
    logic               neg400;
    logic signed [31:0] secs;
  } dec_t;

  typedef struct packed {
    logic signed [26:0] yd365;
    logic [13:0]        q4;
    logic [33:0]        p100;
    logic [31:0]        p400;
    logic [8:0]         dbm;
    logic [7:0]         day;
    logic               neg4;
    logic               neg100;
    logic               neg400;
    logic signed [31:0] secs;
  } mul_t;

  typedef struct packed {
    logic signed [27:0] days;
    logic signed [31:0] secs;
  } day_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/pdte_if.sv @@
// valid/ready channel interfaces for date items and epoch items
`timescale 1ns / 1ps

interface pdte_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        packed_date;
  logic signed [31:0] seconds_of_day;

  modport source (output valid, output packed_date, output seconds_of_day, input ready);
  modport sink   (input valid, input packed_date, input seconds_of_day, output ready);
endinterface

interface pdte_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

@@ rtl/pdte_decode.sv @@
// stage 1: unpack date, normalize month and year, form leap term operands
`timescale 1ns / 1ps

module pdte_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        packed_date,
  input  logic signed [31:0] seconds_of_day,
  output logic               dec_valid,
  output pdte_pkg::dec_t     dec
);

  pdte_pkg::dec_t dec_next;

  always_comb begin
    logic signed [15:0] yr;
    logic [7:0]         mon_raw;
    logic [7:0]         m;
    logic [15:0]        q12_prod;
    logic [4:0]         q12;
    logic [7:0]         rem;
    logic [3:0]         mon;
    logic signed [17:0] yadj;
    logic signed [17:0] ly;
    logic signed [17:0] x4, x100, x400;
    logic signed [17:0] n4, n100, n400;
    yr       = packed_date[31:16];
    mon_raw  = packed_date[15:8];
    m        = mon_raw - 8'd1;
    q12_prod = {8'b0, m} * pdte_pkg::RECIP_12;
    q12      = q12_prod[pdte_pkg::RECIP_12_SH +: 5];
    rem      = m - 8'({q12, 3'b0} + {1'b0, q12, 2'b0});
    if (mon_raw == 8'd0) begin
      yadj = {{2{yr[15]}}, yr} - 18'sd1;
      mon  = pdte_pkg::MONTH_DEC;
    end else begin
      yadj = {{2{yr[15]}}, yr} + {13'b0, q12};
      mon  = rem[3:0];
    end
    ly   = (mon <= pdte_pkg::MONTH_FEB) ? yadj - 18'sd1 : yadj;
    x4   = ly - pdte_pkg::YEAR_LEAP4;
    x100 = ly - pdte_pkg::YEAR_LEAP100;
    x400 = ly - pdte_pkg::YEAR_LEAP400;
    n4   = -x4;
    n100 = -x100;
    n400 = -x400;

    dec_next.yd     = yadj - pdte_pkg::YEAR_EPOCH;
    dec_next.dbm    = pdte_pkg::days_before(mon);
    dec_next.day    = packed_date[7:0];
    dec_next.neg4   = x4[17];
    dec_next.neg100 = x100[17];
    dec_next.neg400 = x400[17];
    dec_next.mag4   = x4[17]   ? n4[15:0]   : x4[15:0];
    dec_next.mag100 = x100[17] ? n100[15:0] : x100[15:0];
    dec_next.mag400 = x400[17] ? n400[15:0] : x400[15:0];
    dec_next.secs   = seconds_of_day;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

@@ rtl/pdte_days.sv @@
// stages 2-3: reciprocal divides, year scaling and day count sum
`timescale 1ns / 1ps

module pdte_days (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           dec_valid,
  input  pdte_pkg::dec_t dec,
  output logic           day_valid,
  output pdte_pkg::day_t day
);

  logic           mul_valid;
  pdte_pkg::mul_t mul;
  pdte_pkg::mul_t mul_next;
  pdte_pkg::day_t day_next;

  always_comb begin
    mul_next.yd365  = dec.yd * pdte_pkg::DAYS_PER_YEAR;
    mul_next.q4     = dec.mag4[15:2];
    mul_next.p100   = {18'b0, dec.mag100} * {16'b0, pdte_pkg::RECIP_100};
    mul_next.p400   = {16'b0, dec.mag400} * {16'b0, pdte_pkg::RECIP_400};
    mul_next.dbm    = dec.dbm;
    mul_next.day    = dec.day;
    mul_next.neg4   = dec.neg4;
    mul_next.neg100 = dec.neg100;
    mul_next.neg400 = dec.neg400;
    mul_next.secs   = dec.secs;
  end

  always_comb begin
    logic [9:0]         q100;
    logic [7:0]         q400;
    logic signed [27:0] t4, t100, t400;
    q100 = mul.p100[pdte_pkg::RECIP_SH +: 10];
    q400 = mul.p400[pdte_pkg::RECIP_SH +: 8];
    t4   = {14'b0, mul.q4};
    t100 = {18'b0, q100};
    t400 = {20'b0, q400};
    if (mul.neg4) begin
      t4 = -t4;
    end
    if (mul.neg100) begin
      t100 = -t100;
    end
    if (mul.neg400) begin
      t400 = -t400;
    end
    day_next.days = {mul.yd365[26], mul.yd365} + {19'b0, mul.dbm} + t4 - t100 + t400
                    + {20'b0, mul.day} - 28'sd1;
    day_next.secs = mul.secs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      day_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= dec_valid;
      day_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul <= mul_next;
      day <= day_next;
    end
  end

endmodule

@@ rtl/pdte_scale.sv @@
// stages 4-5: scale day count to seconds, add seconds of day
`timescale 1ns / 1ps

module pdte_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               day_valid,
  input  pdte_pkg::day_t     day,
  output logic               res_valid,
  output logic signed [63:0] epoch_seconds
);

  logic               prod_valid;
  logic signed [45:0] prod;
  logic signed [31:0] secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= day_valid;
      res_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod          <= day.days * pdte_pkg::SEC_PER_DAY;
      secs          <= day.secs;
      epoch_seconds <= {{18{prod[45]}}, prod} + {{32{secs[31]}}, secs};
    end
  end

endmodule

@@ rtl/packed_date_to_epoch_seconds.sv @@
// top level: packed date plus seconds of day to signed epoch seconds
// path: an accepted item passes the decode, mul, day, prod and result registers in order; a stall holds them all
// throughput: one item per cycle while the output is not stalled; five register stages share one advance enable
// an item is taken whenever the output register is empty or being taken
// reset: synchronous, active high; clears all stage valid bits, no data reset
`timescale 1ns / 1ps

module packed_date_to_epoch_seconds (
  input logic        clk,
  input logic        rst,
  pdte_in_if.sink    dates,
  pdte_out_if.source stamps
);

  logic           en;
  logic           dec_valid;
  pdte_pkg::dec_t dec;
  logic           day_valid;
  pdte_pkg::day_t day;

  assign en           = !stamps.valid || stamps.ready;
  assign dates.ready  = en;

  pdte_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (dates.valid),
    .packed_date    (dates.packed_date),
    .seconds_of_day (dates.seconds_of_day),
    .dec_valid      (dec_valid),
    .dec            (dec)
  );

  pdte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .dec_valid (dec_valid),
    .dec       (dec),
    .day_valid (day_valid),
    .day       (day)
  );

  pdte_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .day_valid     (day_valid),
    .day           (day),
    .res_valid     (stamps.valid),
    .epoch_seconds (stamps.epoch_seconds)
  );

endmodule

@@ rtl/pdte_checker.sv @@
// port-level assertions for the converter, bound to the top level
`timescale 1ns / 1ps

module pdte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] epoch_seconds
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while output stalled");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("result missing after pipeline latency");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(epoch_seconds)))
    else $error("stalled result changed");

endmodule

bind packed_date_to_epoch_seconds pdte_checker u_pdte_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (dates.valid),
  .in_ready      (dates.ready),
  .out_valid     (stamps.valid),
  .out_ready     (stamps.ready),
  .epoch_seconds (stamps.epoch_seconds)
);
